// ----- rtl/core/bpm_pkg.sv -----
package bpm_pkg;

  localparam int PROCESS_ENTRIES = 32;
  localparam int PREFIX_ENTRIES  = 32;

  localparam int PID_AW = (PROCESS_ENTRIES > 1) ? $clog2(PROCESS_ENTRIES) : 1;
  localparam int PFX_AW = (PREFIX_ENTRIES > 1) ? $clog2(PREFIX_ENTRIES) : 1;

  localparam int SCAN_LEN = (PROCESS_ENTRIES > PREFIX_ENTRIES) ? PROCESS_ENTRIES
                                                               : PREFIX_ENTRIES;
  localparam int SCAN_CW  = $clog2(SCAN_LEN + 1);
  localparam int CNT_W    = 6;
  localparam int CMP_W    = (CNT_W > SCAN_CW) ? CNT_W : SCAN_CW;

  localparam int PADDR_W  = 5;
  localparam int PDATA_W  = 32;

  localparam logic [2:0] REG_POLICY_ACTIVE = 3'd0;
  localparam logic [2:0] REG_KILL_SWITCH   = 3'd1;
  localparam logic [2:0] REG_PROCESS_COUNT = 3'd2;
  localparam logic [2:0] REG_DEST_COUNT    = 3'd3;
  localparam logic [2:0] REG_SELF_PID      = 3'd4;

  localparam logic [1:0] ACT_WR_PID = 2'd0;
  localparam logic [1:0] ACT_WR_PFX = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;

  localparam logic [7:0] FAM_IPV4  = 8'd2;
  localparam logic [7:0] LEN_IPV4  = 8'd32;
  localparam logic [7:0] LEN_FULL  = 8'd128;

  typedef struct packed {
    logic             policy_active;
    logic             kill_switch;
    logic [CNT_W-1:0] process_count;
    logic [CNT_W-1:0] dest_count;
    logic [31:0]      self_pid;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  family;
    logic [7:0]  plen;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
  } pfx_entry_t;

  localparam int PFX_W = $bits(pfx_entry_t);

  typedef struct packed {
    logic capture;
    logic wr_pid;
    logic wr_pfx;
    logic scan_clr;
    logic scan_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_busy;
  } dp_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_OUT
  } state_t;

endpackage

// ----- rtl/core/bpm_ram.sv -----
module bpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/bpm_regs.sv -----
module bpm_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bpm_pkg::PADDR_W-1:0] paddr,
  input  logic [bpm_pkg::PDATA_W-1:0] pwdata,
  output logic [bpm_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output bpm_pkg::cfg_t               cfg
);
  import bpm_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_POLICY_ACTIVE: cfg_nxt.policy_active = pwdata[0];
        REG_KILL_SWITCH:   cfg_nxt.kill_switch   = pwdata[0];
        REG_PROCESS_COUNT: cfg_nxt.process_count = pwdata[CNT_W-1:0];
        REG_DEST_COUNT:    cfg_nxt.dest_count    = pwdata[CNT_W-1:0];
        REG_SELF_PID:      cfg_nxt.self_pid      = pwdata[31:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_POLICY_ACTIVE: prdata = {{(PDATA_W-1){1'b0}}, cfg_r.policy_active};
      REG_KILL_SWITCH:   prdata = {{(PDATA_W-1){1'b0}}, cfg_r.kill_switch};
      REG_PROCESS_COUNT: prdata = {{(PDATA_W-CNT_W){1'b0}}, cfg_r.process_count};
      REG_DEST_COUNT:    prdata = {{(PDATA_W-CNT_W){1'b0}}, cfg_r.dest_count};
      REG_SELF_PID:      prdata = cfg_r.self_pid;
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- rtl/core/bpm_ctrl.sv -----
module bpm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_action,
  output logic                in_stall,
  input  bpm_pkg::dp_stat_t   stat,
  output bpm_pkg::ctrl_cmd_t  cmd
);
  import bpm_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          unique case (in_action)
            ACT_WR_PID: cmd.wr_pid = 1'b1;
            ACT_WR_PFX: cmd.wr_pfx = 1'b1;
            ACT_QUERY: begin
              cmd.scan_clr = 1'b1;
              state_nxt    = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/core/bpm_dp.sv -----
module bpm_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  bpm_pkg::cfg_t       cfg,
  input  bpm_pkg::ctrl_cmd_t  cmd,
  output bpm_pkg::dp_stat_t   stat,
  input  logic [4:0]          in_entry_index,
  input  logic [31:0]         in_pid,
  input  logic [7:0]          in_family,
  input  logic [7:0]          in_prefix_len,
  input  logic [63:0]         in_addr_hi,
  input  logic [63:0]         in_addr_lo,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_kill_active,
  output logic                out_process_bypassed,
  output logic                out_dest_bypassed,
  output logic                out_self_pid_match
);
  import bpm_pkg::*;

  logic [31:0]        q_pid_r;
  logic [7:0]         q_family_r;
  logic [63:0]        q_addr_hi_r;
  logic [63:0]        q_addr_lo_r;

  logic [SCAN_CW-1:0] cnt_r;
  logic [SCAN_CW-1:0] cnt_nxt;
  logic               pchk_r;
  logic               dchk_r;
  logic               proc_hit_r;
  logic               proc_hit_nxt;
  logic               dest_hit_r;
  logic               dest_hit_nxt;

  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [3:0]         out_flags_r;

  logic [CMP_W-1:0]   cnt_ext;
  logic [CMP_W-1:0]   n_proc;
  logic [CMP_W-1:0]   n_dest;

  logic               pid_we;
  logic               pfx_we;
  pfx_entry_t         pfx_wdata;
  logic [31:0]        pid_rdata;
  logic [PFX_W-1:0]   pfx_rdata_bits;
  pfx_entry_t         pfx_rdata;

  logic [7:0]         len_limit;
  logic [7:0]         len_eff;
  logic [7:0]         shamt;
  logic [127:0]       mask;
  logic               pfx_match;
  logic               pid_match;

  assign pid_we    = cmd.wr_pid && (in_entry_index < PROCESS_ENTRIES);
  assign pfx_we    = cmd.wr_pfx && (in_entry_index < PREFIX_ENTRIES);
  assign pfx_wdata = '{family: in_family, plen: in_prefix_len,
                       addr_hi: in_addr_hi, addr_lo: in_addr_lo};

  bpm_ram #(
    .WIDTH (32),
    .DEPTH (PROCESS_ENTRIES)
  ) u_pid_ram (
    .clk   (clk),
    .we    (pid_we),
    .waddr (PID_AW'(in_entry_index)),
    .wdata (in_pid),
    .raddr (PID_AW'(cnt_r)),
    .rdata (pid_rdata)
  );

  bpm_ram #(
    .WIDTH (PFX_W),
    .DEPTH (PREFIX_ENTRIES)
  ) u_pfx_ram (
    .clk   (clk),
    .we    (pfx_we),
    .waddr (PFX_AW'(in_entry_index)),
    .wdata (pfx_wdata),
    .raddr (PFX_AW'(cnt_r)),
    .rdata (pfx_rdata_bits)
  );

  assign pfx_rdata = pfx_rdata_bits;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      q_pid_r     <= in_pid;
      q_family_r  <= in_family;
      q_addr_hi_r <= in_addr_hi;
      q_addr_lo_r <= in_addr_lo;
    end
    if (cmd.out_load) begin
      out_flags_r <= {cfg.policy_active && cfg.kill_switch,
                      cfg.policy_active && proc_hit_r,
                      cfg.policy_active && dest_hit_r,
                      cfg.self_pid == q_pid_r};
    end
  end

  assign cnt_ext = CMP_W'(cnt_r);
  assign n_proc  = (CMP_W'(cfg.process_count) > CMP_W'(PROCESS_ENTRIES)) ?
                   CMP_W'(PROCESS_ENTRIES) : CMP_W'(cfg.process_count);
  assign n_dest  = (CMP_W'(cfg.dest_count) > CMP_W'(PREFIX_ENTRIES)) ?
                   CMP_W'(PREFIX_ENTRIES) : CMP_W'(cfg.dest_count);

  assign len_limit = (q_family_r == FAM_IPV4) ? LEN_IPV4 : LEN_FULL;
  assign len_eff   = (pfx_rdata.plen > len_limit) ? len_limit : pfx_rdata.plen;
  assign shamt     = LEN_FULL - len_eff;
  assign mask      = {128{1'b1}} << shamt;
  assign pfx_match = (pfx_rdata.family == q_family_r) &&
                     ((({pfx_rdata.addr_hi, pfx_rdata.addr_lo} ^
                        {q_addr_hi_r, q_addr_lo_r}) & mask) == 128'd0);
  assign pid_match = (pid_rdata == q_pid_r);

  always_comb begin
    cnt_nxt      = cnt_r;
    proc_hit_nxt = proc_hit_r || (pchk_r && pid_match);
    dest_hit_nxt = dest_hit_r || (dchk_r && pfx_match);
    if (cmd.scan_clr) begin
      cnt_nxt      = '0;
      proc_hit_nxt = 1'b0;
      dest_hit_nxt = 1'b0;
    end else if (cmd.scan_step) begin
      cnt_nxt = cnt_r + SCAN_CW'(1);
    end
  end

  assign out_valid_nxt = cmd.out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      pchk_r      <= 1'b0;
      dchk_r      <= 1'b0;
      proc_hit_r  <= 1'b0;
      dest_hit_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      pchk_r      <= cmd.scan_step && (cnt_ext < n_proc);
      dchk_r      <= cmd.scan_step && (cnt_ext < n_dest);
      proc_hit_r  <= proc_hit_nxt;
      dest_hit_r  <= dest_hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign stat.scan_last = (cnt_r == SCAN_CW'(SCAN_LEN - 1));
  assign stat.out_busy  = out_valid_r && out_stall;

  assign out_valid            = out_valid_r;
  assign out_kill_active      = out_flags_r[3];
  assign out_process_bypassed = out_flags_r[2];
  assign out_dest_bypassed    = out_flags_r[1];
  assign out_self_pid_match   = out_flags_r[0];

endmodule

// ----- rtl/core/bypass_policy_matcher_unit.sv -----
// Channel   Handshake             Payload
// in_       in_valid / in_stall   action, entry_index, pid, family, prefix_len,
//                                 addr_hi, addr_lo
// out_      out_valid / out_stall kill_active, process_bypassed, dest_bypassed,
//                                 self_pid_match
// cfg       psel/penable/pwrite   paddr, pwdata, prdata, pready
//
// A table write keeps the FSM idle; the next transaction is taken in the following cycle.
// A query walks both tables one entry per cycle through the single read port of each
// table RAM, then passes a flush state for the last read and an output state that loads
// the result once the result register is free. The result is valid in the cycle after
// the load; the next transaction is taken in that same cycle.
// A synchronous active-low reset clears the config, scan and valid registers and the FSM;
// query, result-flag and table registers are undefined until written.
// A held result does not block acceptance; a finished query waits until the result
// register is free.
module bypass_policy_matcher_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_action,
  input  logic [4:0]                  in_entry_index,
  input  logic [31:0]                 in_pid,
  input  logic [7:0]                  in_family,
  input  logic [7:0]                  in_prefix_len,
  input  logic [63:0]                 in_addr_hi,
  input  logic [63:0]                 in_addr_lo,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_kill_active,
  output logic                        out_process_bypassed,
  output logic                        out_dest_bypassed,
  output logic                        out_self_pid_match,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bpm_pkg::PADDR_W-1:0] paddr,
  input  logic [bpm_pkg::PDATA_W-1:0] pwdata,
  output logic [bpm_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import bpm_pkg::*;

  cfg_t      cfg;
  ctrl_cmd_t dp_cmd;
  dp_stat_t  dp_stat;

  bpm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  bpm_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg),
    .cmd                  (dp_cmd),
    .stat                 (dp_stat),
    .in_entry_index       (in_entry_index),
    .in_pid               (in_pid),
    .in_family            (in_family),
    .in_prefix_len        (in_prefix_len),
    .in_addr_hi           (in_addr_hi),
    .in_addr_lo           (in_addr_lo),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_kill_active      (out_kill_active),
    .out_process_bypassed (out_process_bypassed),
    .out_dest_bypassed    (out_dest_bypassed),
    .out_self_pid_match   (out_self_pid_match)
  );

  a_query_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_action == ACT_QUERY) |=> in_stall)
    else $error("input accepted during a query walk");

  a_no_result_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.out_load |-> !(out_valid && out_stall))
    else $error("result register overwritten while held");

  a_result_from_load : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(dp_cmd.out_load))
    else $error("result appeared without a load");

endmodule
